@@ hdl/bba_pkg.sv @@
// shared constants and types of the bitmap block allocator
package bba_pkg;

  // bitmap word geometry
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WORD_AW   = 5;

  // width of a run length as carried on the ports
  localparam int unsigned CNT_W     = 7;

  // carried free-run length, saturated above any run length that can be asked for
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned RUN_CAP   = 128;

  // command opcodes
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_TEST    = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_CNT = 2'd1,
    ST_NO_FREE  = 2'd2,
    ST_NO_RUN   = 2'd3
  } status_e;

  // what the word search reports for one bitmap word
  typedef struct packed {
    logic               win_hit;   // a whole run fits inside the word
    logic [WORD_AW-1:0] win_pos;   // lowest start of such a run
    logic [WORD_AW:0]   low_free;  // free bits from bit 0 upwards
    logic [WORD_AW:0]   top_free;  // free bits from the top bit downwards
  } srch_t;

endpackage

@@ hdl/bitmap_block_allocator_top.sv @@
// Bitmap block allocator: one used bit per block in a word memory, first-fit allocation.
// After reset the block runs a fill pass over every bitmap word (busy high) that marks
// every block used; the free count starts at zero. Each command is taken when start is
// high and busy is low, and gives exactly one result, shown for one cycle with done_o;
// the receiver cannot stall, so results must be taken in that cycle. Work goes through
// the single word memory (one read per cycle, read data registered). A command refused
// by its checks, or with nothing to do, gives its result without a memory access; test
// reads the word and then checks the bit; free and reserve read and write back each
// bitmap word touched, with a further step when the run reaches past the last bitmap word;
// an allocation reads the words from word 0 upwards until a run is found and then marks
// it, and a search that finds no run reads every word. busy drops in the cycle done_o is
// high, so the next command can be taken at the edge that ends it. The managed limit may be
// written only while busy is low and no result is pending.
module bitmap_block_allocator_top #(
  parameter int unsigned NBLOCKS = 1024,
  parameter int unsigned MAX_RUN = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic [9:0]                   start_block_i,
  input  logic [bba_pkg::CNT_W-1:0]    block_count_i,
  input  logic                         blk_limit_we_i,
  input  logic [10:0]                  blk_limit_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [9:0]                   found_block_o,
  output logic                         block_used_o,
  output logic [10:0]                  free_count_o
);

  localparam int unsigned WB        = bba_pkg::WORD_BITS;
  localparam int unsigned WA        = bba_pkg::WORD_AW;
  localparam int unsigned NUM_WORDS = (NBLOCKS + WB - 1) / WB;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned CW        = $clog2(NBLOCKS + 1);
  localparam int unsigned PW        = (($clog2(NBLOCKS) > 10) ? $clog2(NBLOCKS) : 10) + 1;
  localparam int unsigned LW        = (CW > 11) ? CW : 11;
  localparam int unsigned XW        = (CW > bba_pkg::CNT_W) ? CW : bba_pkg::CNT_W;
  localparam int unsigned TAIL      = NBLOCKS % WB;
  localparam logic [WB-1:0] TAIL_MASK = (TAIL == 0) ? '1 : WB'((33'd1 << TAIL) - 33'd1);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_TEST_RD,
    S_TEST_CHK
  } state_e;

  state_e                   state_q;
  bba_pkg::op_e             op_q;
  bba_pkg::status_e         status_q;
  logic [AW-1:0]            fill_q;
  logic                     done_q;
  logic [CW-1:0]            free_q;
  logic [10:0]              total_q;
  logic [9:0]               found_q;
  logic                     used_q;
  logic [bba_pkg::CNT_W-1:0] cnt_q;
  logic [bba_pkg::CNT_W-1:0] rem_q;
  logic [PW-1:0]            pos_q;
  logic                     set_q;
  logic [AW:0]              rd_word_q;
  logic [AW-1:0]            dat_word_q;
  logic                     dv_q;
  logic [bba_pkg::RUN_W-1:0] run_len_q;
  logic [PW-1:0]            run_start_q;

  // memory port signals
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [WB-1:0]            mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic [WB-1:0]            mem_rdata;

  // command decode
  logic                     cmd_zero;
  logic                     cmd_no_free;
  logic                     cmd_too_long;
  logic [bba_pkg::CNT_W-1:0] cmd_clip;
  logic                     cmd_past_end;

  // scan datapath
  logic [LW-1:0]            lim;
  logic [LW-WA-1:0]         lim_word;
  logic [PW-1:0]            scan_base;
  logic [WB-1:0]            valid_mask;
  logic [WB-1:0]            free_vec;
  bba_pkg::srch_t           srch;
  logic                     carry_hit;
  logic                     scan_hit;
  logic [PW-1:0]            found_pos;
  logic                     all_free;
  logic [bba_pkg::RUN_W-1:0] run_sum;
  logic [bba_pkg::RUN_W-1:0] run_len_next;
  logic [PW-1:0]            run_start_next;

  // mark datapath
  logic [PW-WA-1:0]         mark_wide;
  logic                     mark_in;
  logic [AW-1:0]            mark_addr;
  logic [WA-1:0]            mark_off;
  logic [WA:0]              mark_avail;
  logic [WA:0]              mark_take;
  logic [63:0]              run_span;
  logic [WB-1:0]            wr_mask;
  logic [WB-1:0]            new_word;
  logic [WA:0]              flip_cnt;
  logic [CW-1:0]            free_next;
  logic [bba_pkg::CNT_W-1:0] rem_next;

  // command checks on the port values
  always_comb begin
    cmd_zero     = (block_count_i == '0);
    cmd_no_free  = (XW'(block_count_i) > XW'(free_q));
    cmd_too_long = (11'(block_count_i) > 11'(MAX_RUN));
    cmd_clip     = cmd_too_long ? bba_pkg::CNT_W'(MAX_RUN) : block_count_i;
    cmd_past_end = (32'(start_block_i) >= 32'(NBLOCKS));
  end

  // managed limit and free bits of the word under scan
  always_comb begin
    lim       = (LW'(total_q) > LW'(NBLOCKS)) ? LW'(NBLOCKS) : LW'(total_q);
    lim_word  = lim[LW-1:WA];
    scan_base = PW'({dat_word_q, {WA{1'b0}}});
    if (32'(dat_word_q) < 32'(lim_word)) begin
      valid_mask = '1;
    end else if (32'(dat_word_q) == 32'(lim_word)) begin
      valid_mask = WB'((33'd1 << lim[WA-1:0]) - 33'd1);
    end else begin
      valid_mask = '0;
    end
    free_vec = ~mem_rdata & valid_mask;
  end

  bba_word_search u_search (
    .free_vec_i (free_vec),
    .run_cnt_i  (cnt_q),
    .res_o      (srch)
  );

  // run carried over from earlier words, and the run leaving this word
  always_comb begin
    carry_hit = (run_len_q != '0) &&
                ((9'(run_len_q) + 9'(srch.low_free)) >= 9'(cnt_q));
    scan_hit  = carry_hit || srch.win_hit;
    found_pos = carry_hit ? run_start_q : (scan_base + PW'(srch.win_pos));
    all_free  = srch.low_free[WA];
    run_sum   = run_len_q + bba_pkg::RUN_W'(WB);
    if (all_free) begin
      run_len_next   = (run_sum > bba_pkg::RUN_W'(bba_pkg::RUN_CAP)) ?
                       bba_pkg::RUN_W'(bba_pkg::RUN_CAP) : run_sum;
      run_start_next = (run_len_q == '0) ? scan_base : run_start_q;
    end else begin
      run_len_next   = bba_pkg::RUN_W'(srch.top_free);
      run_start_next = scan_base + PW'(WB) - PW'(srch.top_free);
    end
  end

  // read-modify-write of one word of a run
  always_comb begin
    mark_wide  = pos_q[PW-1:WA];
    mark_in    = (32'(mark_wide) < 32'(NUM_WORDS));
    mark_addr  = AW'(mark_wide);
    mark_off   = pos_q[WA-1:0];
    mark_avail = (WA + 1)'(WB) - (WA + 1)'(mark_off);
    mark_take  = (rem_q < bba_pkg::CNT_W'(mark_avail)) ? (WA + 1)'(rem_q) : mark_avail;
    run_span   = ((64'd1 << mark_take) - 64'd1) << mark_off;
    wr_mask    = run_span[WB-1:0];
    if (32'(mark_addr) == 32'(NUM_WORDS - 1)) begin
      wr_mask = wr_mask & TAIL_MASK;
    end
    new_word   = set_q ? (mem_rdata | wr_mask) : (mem_rdata & ~wr_mask);
    flip_cnt   = (WA + 1)'($countones(new_word ^ mem_rdata));
    free_next  = set_q ? (free_q - CW'(flip_cnt)) : (free_q + CW'(flip_cnt));
    rem_next   = rem_q - bba_pkg::CNT_W'(mark_take);
  end

  // memory port steering; read data is never used from a cycle in which its word is written
  always_comb begin
    mem_we    = (state_q == S_FILL) || (state_q == S_MARK_WR);
    mem_waddr = (state_q == S_FILL) ? fill_q : mark_addr;
    mem_wdata = (state_q == S_FILL) ? '1 : new_word;
    mem_raddr = (state_q == S_SCAN) ? rd_word_q[AW-1:0] : mark_addr;
  end

  bba_mem #(
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      op_q        <= bba_pkg::OP_ALLOC;
      status_q    <= bba_pkg::ST_OK;
      fill_q      <= '0;
      done_q      <= 1'b0;
      free_q      <= '0;
      total_q     <= 11'd1024;
      found_q     <= '0;
      used_q      <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      pos_q       <= '0;
      set_q       <= 1'b0;
      rd_word_q   <= '0;
      dat_word_q  <= '0;
      dv_q        <= 1'b0;
      run_len_q   <= '0;
      run_start_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (blk_limit_we_i) begin
        total_q <= blk_limit_i;
      end
      unique case (state_q)
        S_FILL: begin
          fill_q <= fill_q + AW'(1);
          if (fill_q == AW'(NUM_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q     <= bba_pkg::op_e'(opcode_i);
            status_q <= bba_pkg::ST_OK;
            found_q  <= '0;
            used_q   <= 1'b0;
            pos_q    <= PW'(start_block_i);
            unique case (bba_pkg::op_e'(opcode_i))
              bba_pkg::OP_ALLOC: begin
                priority if (cmd_zero) begin
                  status_q <= bba_pkg::ST_ZERO_CNT;
                  done_q   <= 1'b1;
                end else if (cmd_no_free) begin
                  status_q <= bba_pkg::ST_NO_FREE;
                  done_q   <= 1'b1;
                end else if (cmd_too_long) begin
                  status_q <= bba_pkg::ST_NO_RUN;
                  done_q   <= 1'b1;
                end else begin
                  cnt_q     <= block_count_i;
                  rd_word_q <= '0;
                  dv_q      <= 1'b0;
                  run_len_q <= '0;
                  state_q   <= S_SCAN;
                end
              end
              bba_pkg::OP_FREE, bba_pkg::OP_RESERVE: begin
                rem_q <= cmd_clip;
                set_q <= (bba_pkg::op_e'(opcode_i) == bba_pkg::OP_RESERVE);
                if (cmd_clip == '0) begin
                  done_q <= 1'b1;
                end else begin
                  state_q <= S_MARK_RD;
                end
              end
              bba_pkg::OP_TEST: begin
                if (cmd_past_end) begin
                  used_q <= 1'b1;
                  done_q <= 1'b1;
                end else begin
                  state_q <= S_TEST_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one word requested per cycle, its registered read data checked after the read
          if (rd_word_q < (AW + 1)'(NUM_WORDS)) begin
            rd_word_q <= rd_word_q + (AW + 1)'(1);
            dv_q      <= 1'b1;
          end else begin
            dv_q <= 1'b0;
          end
          dat_word_q <= rd_word_q[AW-1:0];
          if (dv_q) begin
            if (scan_hit) begin
              found_q <= found_pos[9:0];
              pos_q   <= found_pos;
              rem_q   <= cnt_q;
              set_q   <= 1'b1;
              dv_q    <= 1'b0;
              state_q <= S_MARK_RD;
            end else if (dat_word_q == AW'(NUM_WORDS - 1)) begin
              status_q <= bba_pkg::ST_NO_RUN;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              run_len_q   <= run_len_next;
              run_start_q <= run_start_next;
            end
          end
        end
        S_MARK_RD: begin
          // blocks beyond the bitmap are left alone
          if (mark_in) begin
            state_q <= S_MARK_WR;
          end else begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_MARK_WR: begin
          free_q <= free_next;
          pos_q  <= pos_q + PW'(mark_take);
          rem_q  <= rem_next;
          if (rem_next == '0) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MARK_RD;
          end
        end
        S_TEST_RD: begin
          state_q <= S_TEST_CHK;
        end
        S_TEST_CHK: begin
          used_q  <= mem_rdata[pos_q[WA-1:0]];
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // outputs
  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_block_o = found_q;
  assign block_used_o  = used_q;
  assign free_count_o  = 11'(free_q);

  // an accepted command is always followed by work or by its result
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted command neither started nor reported");

  // a granted run lies wholly below the managed limit
  a_alloc_in_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (op_q == bba_pkg::OP_ALLOC) && (status_q == bba_pkg::ST_OK) |->
      (32'(found_q) + 32'(cnt_q) <= 32'(lim)))
    else $error("allocated run crosses the managed limit");

  // the free count never exceeds the number of blocks
  a_free_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(free_q) <= 32'(NBLOCKS)))
    else $error("free count above block total");

  // a write-back step always has blocks left to touch
  a_mark_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK_WR) |-> (rem_q != '0) && $past(state_q == S_MARK_RD))
    else $error("write-back step without remaining blocks");

endmodule

@@ hdl/bba_mem.sv @@
// bitmap word memory, one write port and one registered read port
module bba_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [bba_pkg::WORD_BITS-1:0] wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [bba_pkg::WORD_BITS-1:0] rdata_o
);

  logic [bba_pkg::WORD_BITS-1:0] mem_q [DEPTH];
  logic [bba_pkg::WORD_BITS-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bba_word_search.sv @@
// free-run search inside one bitmap word
module bba_word_search (
  input  logic [bba_pkg::WORD_BITS-1:0] free_vec_i,
  input  logic [bba_pkg::CNT_W-1:0]     run_cnt_i,
  output bba_pkg::srch_t                res_o
);

  localparam int unsigned W = bba_pkg::WORD_BITS;

  logic [W-1:0] len_mask;
  logic [W-1:0] win;
  logic         fits;
  logic         zero_seen;
  logic [bba_pkg::WORD_AW-1:0] hi_zero;
  logic                        hit_any;
  logic [bba_pkg::WORD_AW-1:0] pos_low;
  logic [bba_pkg::WORD_AW:0]   free_low;
  logic [bba_pkg::WORD_AW:0]   free_top;

  // window of run length, anchored at bit 0
  always_comb begin
    fits = (run_cnt_i <= bba_pkg::CNT_W'(W));
    if (run_cnt_i >= bba_pkg::CNT_W'(W)) begin
      len_mask = '1;
    end else begin
      len_mask = W'((33'd1 << run_cnt_i[bba_pkg::WORD_AW-1:0]) - 33'd1);
    end
  end

  // one candidate start per bit, zeros shift in above the top bit
  always_comb begin
    for (int j = 0; j < W; j++) begin
      win[j] = fits && (&((free_vec_i >> j) | ~len_mask));
    end
  end

  // lowest candidate start
  always_comb begin
    hit_any = |win;
    pos_low = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (win[j]) begin
        pos_low = bba_pkg::WORD_AW'(j);
      end
    end
  end

  // free bits at the bottom of the word
  always_comb begin
    free_low = (bba_pkg::WORD_AW + 1)'(W);
    for (int j = W - 1; j >= 0; j--) begin
      if (!free_vec_i[j]) begin
        free_low = (bba_pkg::WORD_AW + 1)'(j);
      end
    end
  end

  // free bits at the top of the word
  always_comb begin
    zero_seen = 1'b0;
    hi_zero   = '0;
    for (int j = 0; j < W; j++) begin
      if (!free_vec_i[j]) begin
        zero_seen = 1'b1;
        hi_zero   = bba_pkg::WORD_AW'(j);
      end
    end
    if (zero_seen) begin
      free_top = (bba_pkg::WORD_AW + 1)'(W - 1) - {1'b0, hi_zero};
    end else begin
      free_top = (bba_pkg::WORD_AW + 1)'(W);
    end
  end

  assign res_o = '{win_hit: hit_any, win_pos: pos_low, low_free: free_low, top_free: free_top};

endmodule
